FILE: design/arr_lcm_pkg.sv
package arr_lcm_pkg;

    localparam int VALUE_WIDTH = 8;
    localparam int FULL_WIDTH  = 64;
    localparam int MUL_STEPS   = VALUE_WIDTH;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic mod_step;
        logic gcd_step;
        logic div_step;
        logic mul_step;
        logic emit;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic need_combine;
        logic cnt_zero;
        logic gcd_done;
        logic item_last;
    } status_t;

endpackage

FILE: design/arr_lcm_ctrl.sv
module arr_lcm_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_last,
    output logic                  in_ready,
    input  logic                  out_ready,
    output logic                  out_valid,
    input  arr_lcm_pkg::status_t  status,
    output arr_lcm_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_GCD,
        S_DIV,
        S_MUL,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   emit_ok;

    assign emit_ok   = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.need_combine)
                    begin
                        state_next = S_MOD;
                    end
                    else if (in_last)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.cnt_zero)
                begin
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (status.gcd_done)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.cnt_zero)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (status.cnt_zero)
                begin
                    state_next = status.item_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/arr_lcm_dp.sv
module arr_lcm_dp
#(
    parameter int LCM_WIDTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            value,
    input  logic                  last,
    input  arr_lcm_pkg::cmd_t     cmd,
    output arr_lcm_pkg::status_t  status,
    output logic [7:0]            lcm_low,
    output logic [63:0]           lcm_full,
    output logic                  overflowed,
    output logic                  had_zero
);

    localparam int CW = $clog2(LCM_WIDTH);
    localparam int AW = LCM_WIDTH + arr_lcm_pkg::VALUE_WIDTH;

    logic [LCM_WIDTH-1:0] running_reg, running_next;
    logic                 first_reg, first_next;
    logic                 ovf_reg, ovf_next;
    logic                 zero_reg, zero_next;
    logic [7:0]           val_reg, val_next;
    logic                 last_reg, last_next;
    logic [LCM_WIDTH-1:0] work_reg, work_next;
    logic [7:0]           rem_reg, rem_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [7:0]           gx_reg, gx_next;
    logic [7:0]           gy_reg, gy_next;
    logic [AW-1:0]        acc_reg, acc_next;
    logic [63:0]          out_full_reg, out_full_next;
    logic                 out_ovf_reg, out_ovf_next;
    logic                 out_zero_reg, out_zero_next;

    logic [8:0]           rem_shift;
    logic [8:0]           divisor;
    logic                 rem_ge;
    logic [8:0]           rem_diff;
    logic [AW-1:0]        acc_step;
    logic                 prod_ovf;

    assign status.need_combine = (value != 8'd0) && !first_reg && !zero_reg && !ovf_reg;
    assign status.cnt_zero     = (cnt_reg == '0);
    assign status.gcd_done     = (gy_reg == 8'd0);
    assign status.item_last    = last_reg;

    assign lcm_full   = out_full_reg;
    assign lcm_low    = out_full_reg[7:0];
    assign overflowed = out_ovf_reg;
    assign had_zero   = out_zero_reg;

    // one restoring division bit, shared by the remainder and quotient passes
    assign divisor   = {1'b0, (cmd.div_step ? gx_reg : val_reg)};
    assign rem_shift = {rem_reg, work_reg[LCM_WIDTH-1]};
    assign rem_ge    = (rem_shift >= divisor);
    assign rem_diff  = rem_ge ? (rem_shift - divisor) : rem_shift;

    // shift-add multiply of the quotient by the element, msb of the element first
    assign acc_step = {acc_reg[AW-2:0], 1'b0}
                    + (val_reg[cnt_reg[2:0]] ? AW'(work_reg) : '0);
    assign prod_ovf = |acc_step[AW-1:LCM_WIDTH];

    always_comb
    begin
        running_next  = running_reg;
        first_next    = first_reg;
        ovf_next      = ovf_reg;
        zero_next     = zero_reg;
        val_next      = val_reg;
        last_next     = last_reg;
        work_next     = work_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        gx_next       = gx_reg;
        gy_next       = gy_reg;
        acc_next      = acc_reg;
        out_full_next = out_full_reg;
        out_ovf_next  = out_ovf_reg;
        out_zero_next = out_zero_reg;

        if (cmd.accept)
        begin
            val_next   = value;
            last_next  = last;
            first_next = 1'b0;
            if (value == 8'd0)
            begin
                zero_next    = 1'b1;
                running_next = '0;
            end
            else if (first_reg)
            begin
                running_next = LCM_WIDTH'(value);
            end
            work_next = running_reg;
            rem_next  = '0;
            cnt_next  = CW'(LCM_WIDTH - 1);
        end

        if (cmd.mod_step)
        begin
            work_next = {work_reg[LCM_WIDTH-2:0], 1'b0};
            rem_next  = rem_diff[7:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                // remainder done: seed gcd, reload running value for the quotient
                gx_next   = val_reg;
                gy_next   = rem_diff[7:0];
                work_next = running_reg;
                rem_next  = '0;
                cnt_next  = CW'(LCM_WIDTH - 1);
            end
        end

        if (cmd.gcd_step)
        begin
            if (gx_reg >= gy_reg)
            begin
                gx_next = gx_reg - gy_reg;
            end
            else
            begin
                gx_next = gy_reg;
                gy_next = gx_reg;
            end
        end

        if (cmd.div_step)
        begin
            work_next = {work_reg[LCM_WIDTH-2:0], rem_ge};
            rem_next  = rem_diff[7:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                acc_next = '0;
                cnt_next = CW'(arr_lcm_pkg::MUL_STEPS - 1);
            end
        end

        if (cmd.mul_step)
        begin
            acc_next = acc_step;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                if (prod_ovf)
                begin
                    ovf_next     = 1'b1;
                    running_next = '1;
                end
                else
                begin
                    running_next = acc_step[LCM_WIDTH-1:0];
                end
            end
        end

        if (cmd.emit)
        begin
            out_full_next = zero_reg ? 64'd0 : 64'(running_reg);
            out_ovf_next  = ovf_reg;
            out_zero_next = zero_reg;
            // drop array state so the next element opens a new array
            running_next  = '0;
            first_next    = 1'b1;
            ovf_next      = 1'b0;
            zero_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
            first_reg   <= 1'b1;
            ovf_reg     <= 1'b0;
            zero_reg    <= 1'b0;
            last_reg    <= 1'b0;
            cnt_reg     <= '0;
            gy_reg      <= '0;
        end
        else
        begin
            running_reg <= running_next;
            first_reg   <= first_next;
            ovf_reg     <= ovf_next;
            zero_reg    <= zero_next;
            last_reg    <= last_next;
            cnt_reg     <= cnt_next;
            gy_reg      <= gy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        work_reg     <= work_next;
        rem_reg      <= rem_next;
        gx_reg       <= gx_next;
        acc_reg      <= acc_next;
        out_full_reg <= out_full_next;
        out_ovf_reg  <= out_ovf_next;
        out_zero_reg <= out_zero_next;
    end

endmodule

FILE: design/array_lcm_accumulator_unit.sv
// Running least common multiple over arrays of unsigned 8-bit elements, one
// element per request, the last one flagged; one result per array with the
// lcm (saturated at 2^LCM_WIDTH-1 with a sticky overflow flag, or 0 with a
// zero flag when any element is 0). An element that starts an array, is
// zero, or follows a zero or an overflow is taken without a divide or gcd.
// Any other element is folded into the running value by a shared
// one-bit-per-cycle divider and a subtractive gcd: the element is taken, the
// running value is reduced mod the element, the gcd of the element and that
// remainder runs until it is seen to finish, the running value is divided by
// the gcd, and the quotient is multiplied by the element in shift-add steps.
// The last element then loads the output register once it is free; the next
// element is taken while a result still waits.
module array_lcm_accumulator_unit
#(
    parameter int LCM_WIDTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  value,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  lcm_low,
    output logic [63:0] lcm_full,
    output logic        overflowed,
    output logic        had_zero
);

    arr_lcm_pkg::cmd_t    cmd;
    arr_lcm_pkg::status_t status;

    arr_lcm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (last),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .status    (status),
        .cmd       (cmd)
    );

    arr_lcm_dp
    #(
        .LCM_WIDTH (LCM_WIDTH)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .last       (last),
        .cmd        (cmd),
        .status     (status),
        .lcm_low    (lcm_low),
        .lcm_full   (lcm_full),
        .overflowed (overflowed),
        .had_zero   (had_zero)
    );

endmodule
